// File: hw/rtl/prq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process ready queue package
// Sizes, opcodes, status codes and the slot and result types that the
// ready queue modules share.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int HANDLE_W    = 8;
   localparam int PRIO_W      = 8;
   localparam int OPCODE_W    = 2;
   localparam int STATUS_W    = 2;

   localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   prio;
   } slot_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                out_valid;
      logic [HANDLE_W-1:0] out_handle;
      logic [PRIO_W-1:0]   out_priority;
      logic [CNT_W-1:0]    entry_count;
      logic                is_empty;
   } result_type;

endpackage

// File: hw/rtl/prq_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process ready queue channels
// Valid/ready interfaces for the request and the response channel.
// ----------------------------------------------------------------------------
interface prq_req_if;
   logic                           valid;
   logic                           ready;
   logic [prq_pkg::OPCODE_W-1:0]   opcode;
   logic [prq_pkg::HANDLE_W-1:0]   handle;
   logic [prq_pkg::PRIO_W-1:0]     priority_req;

   modport source (output valid, opcode, handle, priority_req, input ready);
   modport sink (input valid, opcode, handle, priority_req, output ready);
endinterface

interface prq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [prq_pkg::STATUS_W-1:0]   status;
   logic                           out_valid;
   logic [prq_pkg::HANDLE_W-1:0]   out_handle;
   logic [prq_pkg::PRIO_W-1:0]     out_priority;
   logic [prq_pkg::CNT_W-1:0]      entry_count;
   logic                           is_empty;

   modport source (output valid, status, out_valid, out_handle, out_priority,
                   entry_count, is_empty, input ready);
   modport sink (input valid, status, out_valid, out_handle, out_priority,
                 entry_count, is_empty, output ready);
endinterface

// File: hw/rtl/process_ready_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process ready queue unit
// Bounded ready queue of process handles with FIFO and priority dequeue.
// ----------------------------------------------------------------------------
// Enqueue, query and any request on an empty queue go from acceptance
// straight to the response state. Dequeue and remove scan the slot RAM one
// read per cycle and then compact one slot per cycle; a FIFO dequeue scans
// one slot.
// One request is in work at a time; a new one is taken while a result waits.
// Reset empties the queue and selects FIFO mode; the RAM is not cleared.
module process_ready_queue_unit (
   input  logic         clock,
   input  logic         reset,
   prq_req_if.sink      req_chan,
   prq_rsp_if.source    rsp_chan,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic                 mode_ff, mode_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   prq_pkg::result_type  rsp_data_ff, rsp_data_in;
   logic                 out_free;
   logic                 eng_valid;
   prq_pkg::result_type  eng_result;

   prq_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_opcode    (req_chan.opcode),
      .req_handle    (req_chan.handle),
      .req_priority  (req_chan.priority_req),
      .priority_mode (mode_ff),
      .out_free      (out_free),
      .result_valid  (eng_valid),
      .result        (eng_result)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      rsp_valid_in = out_free ? eng_valid : rsp_valid_ff;
      rsp_data_in  = (out_free && eng_valid) ? eng_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.out_valid    = rsp_data_ff.out_valid;
   assign rsp_chan.out_handle   = rsp_data_ff.out_handle;
   assign rsp_chan.out_priority = rsp_data_ff.out_priority;
   assign rsp_chan.entry_count  = rsp_data_ff.entry_count;
   assign rsp_chan.is_empty     = rsp_data_ff.is_empty;

endmodule

// File: hw/rtl/prq_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module prq_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] slot_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/prq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue engine
// Sequencer that scans the slot RAM for the entry to take out and then
// closes the gap by moving later slots down one at a time.
// ----------------------------------------------------------------------------
module prq_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [prq_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [prq_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [prq_pkg::PRIO_W-1:0]    req_priority,
   input  logic                          priority_mode,
   input  logic                          out_free,
   output logic                          result_valid,
   output prq_pkg::result_type           result
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type                      state_ff, state_in;
   logic [prq_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [prq_pkg::OPCODE_W-1:0]   op_ff, op_in;
   logic [prq_pkg::HANDLE_W-1:0]   key_ff, key_in;
   logic [prq_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [prq_pkg::CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [prq_pkg::CNT_W-1:0]      scan_end_ff, scan_end_in;
   logic                           pend_ff, pend_in;
   logic [prq_pkg::CNT_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                           found_ff, found_in;
   logic [prq_pkg::CNT_W-1:0]      pick_idx_ff, pick_idx_in;
   prq_pkg::slot_type              pick_slot_ff, pick_slot_in;

   logic                           mem_wr_en;
   logic [prq_pkg::IDX_W-1:0]      mem_wr_addr;
   prq_pkg::slot_type              mem_wr_data;
   logic                           mem_rd_en;
   logic [prq_pkg::IDX_W-1:0]      mem_rd_addr;
   prq_pkg::slot_type              mem_rd_data;
   logic [prq_pkg::CNT_W-1:0]      shift_dst;
   logic                           take_slot;
   logic                           dequeue_ok;

   prq_slot_ram #(
      .DEPTH (prq_pkg::QUEUE_DEPTH),
      .WIDTH ($bits(prq_pkg::slot_type))
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign shift_dst = pend_idx_ff - prq_pkg::CNT_W'(1);

   // During a scan, decide whether the slot whose data just came back
   // becomes the candidate. Remove keeps the first match; dequeue keeps the
   // first slot, then any strictly smaller priority in priority mode.
   always_comb begin
      take_slot = 1'b0;
      if (pend_ff) begin
         if (op_ff == prq_pkg::OP_REMOVE) begin
            take_slot = !found_ff && (mem_rd_data.handle == key_ff);
         end else begin
            take_slot = !found_ff ||
                        (priority_mode && (mem_rd_data.prio < pick_slot_ff.prio));
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      rd_idx_in    = rd_idx_ff;
      scan_end_in  = scan_end_ff;
      pend_in      = 1'b0;
      pend_idx_in  = rd_idx_ff;
      found_in     = found_ff;
      pick_idx_in  = pick_idx_ff;
      pick_slot_in = pick_slot_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_opcode;
               key_in    = req_handle;
               status_in = prq_pkg::ST_OK;
               found_in  = 1'b0;
               rd_idx_in = '0;
               state_in  = S_RESP;
               case (req_opcode)
                  prq_pkg::OP_ENQUEUE: begin
                     if (count_ff < prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH)) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[prq_pkg::IDX_W-1:0];
                        mem_wr_data = '{handle: req_handle, prio: req_priority};
                        count_in    = count_ff + prq_pkg::CNT_W'(1);
                     end else begin
                        status_in = prq_pkg::ST_FULL;
                     end
                  end
                  prq_pkg::OP_DEQUEUE, prq_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = prq_pkg::ST_EMPTY;
                     end else begin
                        // A FIFO dequeue only needs the head slot.
                        if (req_opcode == prq_pkg::OP_DEQUEUE && !priority_mode) begin
                           scan_end_in = prq_pkg::CNT_W'(1);
                        end else begin
                           scan_end_in = count_ff;
                        end
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (rd_idx_ff < scan_end_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_idx_ff[prq_pkg::IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + prq_pkg::CNT_W'(1);
               pend_in     = 1'b1;
            end
            if (take_slot) begin
               found_in     = 1'b1;
               pick_idx_in  = pend_idx_ff;
               pick_slot_in = mem_rd_data;
            end
            if (rd_idx_ff == scan_end_ff && !pend_ff) begin
               if (!found_ff) begin
                  status_in = prq_pkg::ST_NOT_FOUND;
                  state_in  = S_RESP;
               end else begin
                  rd_idx_in = pick_idx_ff + prq_pkg::CNT_W'(1);
                  state_in  = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            // Reads run one slot ahead of the write that moves data down.
            if (rd_idx_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_idx_ff[prq_pkg::IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + prq_pkg::CNT_W'(1);
               pend_in     = 1'b1;
            end
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = shift_dst[prq_pkg::IDX_W-1:0];
               mem_wr_data = mem_rd_data;
            end
            if (rd_idx_ff == count_ff && !pend_ff) begin
               count_in = count_ff - prq_pkg::CNT_W'(1);
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      rd_idx_ff    <= rd_idx_in;
      scan_end_ff  <= scan_end_in;
      pend_idx_ff  <= pend_idx_in;
      found_ff     <= found_in;
      pick_idx_ff  <= pick_idx_in;
      pick_slot_ff <= pick_slot_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign result_valid = (state_ff == S_RESP);
   assign dequeue_ok   = (op_ff == prq_pkg::OP_DEQUEUE) && (status_ff == prq_pkg::ST_OK);

   always_comb begin
      result.status       = status_ff;
      result.out_valid    = dequeue_ok;
      result.out_handle   = dequeue_ok ? pick_slot_ff.handle : '0;
      result.out_priority = dequeue_ok ? pick_slot_ff.prio : '0;
      result.entry_count  = count_ff;
      result.is_empty     = (count_ff == '0);
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) ||
               (count_ff == $past(count_ff) + prq_pkg::CNT_W'(1)) ||
               (count_ff == $past(count_ff) - prq_pkg::CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && state_ff == S_SHIFT) |-> (pend_idx_ff < count_ff))
      else $error("compaction write outside the held entries");

   a_resp_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && out_free) |=> (state_ff == S_IDLE))
      else $error("response not handed off when the output was free");
`endif

endmodule
